/* hw/rtl/btex_pkg.sv */
// Bilinear texture sampler package: sizes, codes, command and config types.
// No dependencies; imported by every module of the sampler.
package btex_pkg;

  localparam int STORE_TEXELS     = 65536;
  localparam int WEIGHT_FRAC_BITS = 8;

  localparam int STORE_AW  = $clog2(STORE_TEXELS);
  localparam int IDX_W     = 16;
  localparam int ADDR_W    = 16;   // (255 * 256 + 255) fits
  localparam int COORD_W   = 17;
  localparam int SIZE_W    = 9;
  localparam int CELL_W    = 8;
  localparam int POS_W     = 26;   // Q1.16 times 256, plus one half
  localparam int CHAN_W    = 16;
  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 32;
  localparam int RES_W     = 24;
  localparam int WT_W      = 2 * WEIGHT_FRAC_BITS + 1;
  localparam int ACC_W     = 2 * WEIGHT_FRAC_BITS + 18;
  localparam int OUT_SHIFT = 2 * WEIGHT_FRAC_BITS - 8;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef enum logic [1:0] {
    FMT_GREY8  = 2'd0,
    FMT_GREY16 = 2'd1,
    FMT_RGB    = 2'd2,
    FMT_RGBA   = 2'd3
  } fmt_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_FIN
  } back_state_t;

  typedef struct packed {
    fmt_t              fmt;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
  } cfg_t;

  // One queued command: a store write or a fully resolved sample.
  typedef struct packed {
    logic                       act;
    logic [IDX_W-1:0]           idx;
    logic [WORD_W-1:0]          word;
    logic [ADDR_W-1:0]          row0;
    logic [ADDR_W-1:0]          row1;
    logic [CELL_W-1:0]          x0;
    logic [CELL_W-1:0]          x1;
    logic [3:0][WT_W-1:0]       wt;    // bit 0 of the slot picks row1, bit 1 picks x1
  } cmd_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s == '0) r = SIZE_W'(1);
    else if (s > SIZE_W'(256)) r = SIZE_W'(256);
    return r;
  endfunction

endpackage

/* hw/rtl/bilinear_texture_sampler.sv */
// Bilinear texture sampler top level: ports, config registers, front/queue/back.
// Depends on btex_pkg, btex_front, btex_queue, btex_back.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  in_     | sink      | in_tvalid/in_tready   | tuser action, tdata texel and coords
//  out_    | source    | out_tvalid/out_tready | tdata red, green, blue (Q.8 signed)
//  cfg_    | sink      | cfg_valid/cfg_ready   | cfg_index register, cfg_data value
//
// A write item takes one store write in the back end; a sample item takes four single-port
// store reads, one per texel, plus a final add into the result register. The front
// end has two pipeline stages, and a four-entry queue lets it keep taking
// items while the back end is busy. Reset (rst_n low, synchronous) clears control
// state and loads pixel_format 2, image_width 256, image_height 256; store contents
// are undefined until written. A stalled out_tready holds the result and, once the
// queue fills, back-pressures in_tready.
module bilinear_texture_sampler
  import btex_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [0:0]  in_tuser,    // action
  input  logic [87:0] in_tdata,    // texel_index, chan0, chan1, chan2, coord_u, coord_v
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,   // red_out, green_out, blue_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  cfg_t cfg_r, cfg_nxt;

  logic q_push_valid, q_push_ready;
  cmd_t q_push_cmd;
  logic q_pop_valid, q_pop_ready;
  cmd_t q_pop_cmd;

  logic [RES_W-1:0] red, green, blue;

  // Config registers; always ready.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_FORMAT: cfg_nxt.fmt    = fmt_t'(cfg_data[1:0]);
        REG_WIDTH:  cfg_nxt.width  = cfg_data;
        REG_HEIGHT: cfg_nxt.height = cfg_data;
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fmt    <= FMT_RGB;
      cfg_r.width  <= SIZE_W'(256);
      cfg_r.height <= SIZE_W'(256);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  btex_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_act   (in_tuser[0]),
    .in_idx   (in_tdata[15:0]),
    .in_chan0 (in_tdata[31:16]),
    .in_chan1 (in_tdata[39:32]),
    .in_chan2 (in_tdata[47:40]),
    .in_u     (in_tdata[64:48]),
    .in_v     (in_tdata[81:65]),
    .q_valid  (q_push_valid),
    .q_ready  (q_push_ready),
    .q_cmd    (q_push_cmd)
  );

  btex_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_cmd   (q_push_cmd),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_cmd    (q_pop_cmd)
  );

  btex_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fmt       (cfg_r.fmt),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_cmd   (q_pop_cmd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_red   (red),
    .out_green (green),
    .out_blue  (blue)
  );

  assign out_tdata = {blue, green, red};

endmodule

/* hw/rtl/btex_front.sv */
// Front end: takes input items, scales coordinates, resolves cells, rows and weights.
// Depends on btex_pkg.
module btex_front
  import btex_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_act,
  input  logic [IDX_W-1:0]   in_idx,
  input  logic [CHAN_W-1:0]  in_chan0,
  input  logic [BYTE_W-1:0]  in_chan1,
  input  logic [BYTE_W-1:0]  in_chan2,
  input  logic [COORD_W-1:0] in_u,
  input  logic [COORD_W-1:0] in_v,
  output logic               q_valid,
  input  logic               q_ready,
  output cmd_t               q_cmd
);

  localparam int F    = WEIGHT_FRAC_BITS;
  localparam int HALF = 32768;

  logic              s1_v_r, s1_v_nxt;
  logic              s1_act_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic [WORD_W-1:0] s1_word_r;
  logic [POS_W-1:0]  s1_pu_r, s1_pv_r;

  logic s2_v_r, s2_v_nxt;
  cmd_t s2_cmd_r, s2_cmd_nxt;

  logic s1_en, s2_en;
  logic [SIZE_W-1:0] w_eff, h_eff;
  logic [POS_W-1:0]  pu_c, pv_c;

  logic [SIZE_W:0]   cu, cv;            // cell + 1
  logic [CELL_W-1:0] wlim, hlim;
  logic [CELL_W-1:0] x0, x1, y0, y1;
  logic [F-1:0]      a, b;
  logic [F:0]        wa0, wb0;

  assign w_eff = clamp_size(cfg.width);
  assign h_eff = clamp_size(cfg.height);

  assign s2_en    = !s2_v_r || q_ready;
  assign s1_en    = !s1_v_r || s2_en;
  assign in_ready = s1_en;

  assign pu_c = POS_W'(in_u) * POS_W'(w_eff) + POS_W'(HALF);
  assign pv_c = POS_W'(in_v) * POS_W'(h_eff) + POS_W'(HALF);

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (s1_en) s1_v_nxt = in_valid;
    else if (s2_en) s1_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      s1_act_r  <= in_act;
      s1_idx_r  <= in_idx;
      s1_word_r <= {in_chan2, in_chan1, in_chan0};
      s1_pu_r   <= pu_c;
      s1_pv_r   <= pv_c;
    end
  end

  // Stage 2: floor, clamp to edge, row bases and the four weight products.
  always_comb begin
    cu   = s1_pu_r[POS_W-1:16];
    cv   = s1_pv_r[POS_W-1:16];
    wlim = CELL_W'(w_eff - SIZE_W'(1));
    hlim = CELL_W'(h_eff - SIZE_W'(1));

    if (cu == '0) x0 = '0;
    else if ((cu - (SIZE_W+1)'(1)) > (SIZE_W+1)'(wlim)) x0 = wlim;
    else x0 = CELL_W'(cu - (SIZE_W+1)'(1));
    if (cu > (SIZE_W+1)'(wlim)) x1 = wlim;
    else x1 = CELL_W'(cu);

    if (cv == '0) y0 = '0;
    else if ((cv - (SIZE_W+1)'(1)) > (SIZE_W+1)'(hlim)) y0 = hlim;
    else y0 = CELL_W'(cv - (SIZE_W+1)'(1));
    if (cv > (SIZE_W+1)'(hlim)) y1 = hlim;
    else y1 = CELL_W'(cv);

    a   = s1_pu_r[15 -: F];
    b   = s1_pv_r[15 -: F];
    wa0 = (F+1)'(1 << F) - (F+1)'(a);
    wb0 = (F+1)'(1 << F) - (F+1)'(b);

    s2_cmd_nxt.act   = s1_act_r;
    s2_cmd_nxt.idx   = s1_idx_r;
    s2_cmd_nxt.word  = s1_word_r;
    s2_cmd_nxt.row0  = ADDR_W'(ADDR_W'(y0) * ADDR_W'(w_eff));
    s2_cmd_nxt.row1  = ADDR_W'(ADDR_W'(y1) * ADDR_W'(w_eff));
    s2_cmd_nxt.x0    = x0;
    s2_cmd_nxt.x1    = x1;
    s2_cmd_nxt.wt[0] = WT_W'(wa0) * WT_W'(wb0);
    s2_cmd_nxt.wt[1] = WT_W'(wa0) * WT_W'(b);
    s2_cmd_nxt.wt[2] = WT_W'(a) * WT_W'(wb0);
    s2_cmd_nxt.wt[3] = WT_W'(a) * WT_W'(b);

    s2_v_nxt = s2_v_r;
    if (s2_en) s2_v_nxt = s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_v_r) begin
      s2_cmd_r <= s2_cmd_nxt;
    end
  end

  assign q_valid = s2_v_r;
  assign q_cmd   = s2_cmd_r;

endmodule

/* hw/rtl/btex_queue.sv */
// Short command queue between front and back end.
// Depends on btex_pkg (cmd_t, QDEPTH).
module btex_queue
  import btex_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != (QPTR_W+1)'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_cmd    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) count_nxt = count_r + (QPTR_W+1)'(1);
    else if (do_pop && !do_push) count_nxt = count_r - (QPTR_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_cmd;
  end

endmodule

/* hw/rtl/btex_back.sv */
// Back end: texel store, four-read fetch sequencer, blend accumulators, result register.
// Depends on btex_pkg.
module btex_back
  import btex_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  fmt_t             fmt,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  cmd_t             pop_cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [RES_W-1:0] out_red,
  output logic [RES_W-1:0] out_green,
  output logic [RES_W-1:0] out_blue
);

  logic [WORD_W-1:0] store [STORE_TEXELS];

  back_state_t state_r, state_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        rd_vld_r, rd_vld_nxt;
  logic [1:0]  rd_sel_r, rd_sel_nxt;
  logic        rd_oor_r;
  logic [WORD_W-1:0] rd_data_r;
  cmd_t        cur_r;
  logic        cur_load;

  logic signed [ACC_W-1:0] acc_r [3];
  logic signed [ACC_W-1:0] acc_nxt [3];
  logic signed [ACC_W-1:0] sum_c [3];
  logic signed [ACC_W-1:0] prod [3];
  logic signed [CHAN_W-1:0] tch [3];
  logic signed [WT_W:0]     wt_s;

  logic              out_valid_r, out_valid_nxt;
  logic              out_load;
  logic [RES_W-1:0]  out_red_r, out_green_r, out_blue_r;

  logic              mem_we, mem_re;
  logic [1:0]        rd_k;
  cmd_t              rd_src;
  logic [ADDR_W-1:0] rd_addr;
  logic [31:0]       rd_ext, wr_ext;
  logic              colour;

  // Texel decode and per-lane products.
  always_comb begin
    colour = (fmt == FMT_RGB) || (fmt == FMT_RGBA);
    if (rd_oor_r) begin
      tch[0] = '0;
    end else if (fmt == FMT_GREY16) begin
      tch[0] = rd_data_r[15:0];
    end else begin
      tch[0] = {8'b0, rd_data_r[7:0]};
    end
    tch[1] = tch[0];
    tch[2] = tch[0];
    if (colour) begin
      tch[1] = rd_oor_r ? '0 : {8'b0, rd_data_r[23:16]};
      tch[2] = rd_oor_r ? '0 : {8'b0, rd_data_r[31:24]};
    end
    wt_s = {1'b0, cur_r.wt[rd_sel_r]};
    for (int i = 0; i < 3; i++) begin
      prod[i]  = ACC_W'(tch[i]) * ACC_W'(wt_s);
      sum_c[i] = acc_r[i] + (rd_vld_r ? prod[i] : ACC_W'(0));
    end
  end

  // Fetch sequencer.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rd_vld_nxt    = 1'b0;
    rd_sel_nxt    = rd_sel_r;
    pop_ready     = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    rd_k          = cnt_r;
    rd_src        = cur_r;
    cur_load      = 1'b0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    for (int i = 0; i < 3; i++) acc_nxt[i] = sum_c[i];

    case (state_r)
      BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          if (pop_cmd.act == ACT_WRITE) begin
            mem_we = 1'b1;
          end else begin
            cur_load   = 1'b1;
            mem_re     = 1'b1;
            rd_k       = 2'd0;
            rd_src     = pop_cmd;
            rd_vld_nxt = 1'b1;
            rd_sel_nxt = 2'd0;
            cnt_nxt    = 2'd1;
            for (int i = 0; i < 3; i++) acc_nxt[i] = '0;
            state_nxt  = BK_READ;
          end
        end
      end
      BK_READ: begin
        mem_re     = 1'b1;
        rd_vld_nxt = 1'b1;
        rd_sel_nxt = cnt_r;
        cnt_nxt    = cnt_r + 2'd1;
        if (cnt_r == 2'd3) state_nxt = BK_FIN;
      end
      BK_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    rd_addr = (rd_k[0] ? rd_src.row1 : rd_src.row0)
            + ADDR_W'(rd_k[1] ? rd_src.x1 : rd_src.x0);
    rd_ext  = 32'(rd_addr);
    wr_ext  = 32'(pop_cmd.idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      rd_sel_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      rd_sel_r    <= rd_sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cur_load) cur_r <= pop_cmd;
    for (int i = 0; i < 3; i++) acc_r[i] <= acc_nxt[i];
    if (out_load) begin
      out_red_r   <= sum_c[0][OUT_SHIFT +: RES_W];
      out_green_r <= sum_c[1][OUT_SHIFT +: RES_W];
      out_blue_r  <= sum_c[2][OUT_SHIFT +: RES_W];
    end
  end

  // Single-port store: one write or one read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we && (wr_ext < 32'(STORE_TEXELS))) begin
      store[wr_ext[STORE_AW-1:0]] <= pop_cmd.word;
    end
    if (mem_re) begin
      rd_data_r <= store[rd_ext[STORE_AW-1:0]];
      rd_oor_r  <= (rd_ext >= 32'(STORE_TEXELS));
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

endmodule

/* test/btex_tb_pkg.sv */
// Shared verification types and coordinate math for the bilinear sampler bench.
// Depends on btex_pkg; imported by btex_checker and tb_top.
package btex_tb_pkg;
  import btex_pkg::*;

  // Index 3 has no register behind it; a write there must change nothing.
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam int WT_ONE = 1 << WEIGHT_FRAC_BITS;

  typedef logic signed [RES_W-1:0] chan_q8_t;

  // Declared high field first so red lands in the low bits, as on out_tdata.
  typedef struct packed {
    chan_q8_t blue;
    chan_q8_t green;
    chan_q8_t red;
  } rgb_q8_t;

  function automatic int usable_size(logic [SIZE_W-1:0] s);
    if (s == '0) return 1;
    if (s > SIZE_W'(256)) return 256;
    return int'(s);
  endfunction

  function automatic int clamp_cell(int c, int size);
    if (c < 0) return 0;
    if (c > size - 1) return size - 1;
    return c;
  endfunction

  // Position coord*size - 0.5: clamped neighbor cells and the weight of hi.
  function automatic void split_coord(input logic [COORD_W-1:0] coord, input int size,
                                      output int lo, output int hi, output int frac);
    longint pos;
    int     lo_raw;
    pos    = longint'(coord) * size + 32768;  // biased up by one cell, never negative
    lo_raw = int'(pos >>> 16) - 1;
    frac   = int'(pos[15:0] >> (16 - WEIGHT_FRAC_BITS));
    lo     = clamp_cell(lo_raw, size);
    hi     = clamp_cell(lo_raw + 1, size);
  endfunction

endpackage

/* test/btex_checker.sv */
// Checker for the bilinear sampler: watches config, input and result channels,
// predicts every sample result and compares it. Depends on btex_pkg, btex_tb_pkg.
module btex_checker
  import btex_pkg::*;
  import btex_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [0:0]  in_tuser,
  input  logic [87:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  output int          failures,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  bit [WORD_W-1:0]   texel_mem [STORE_TEXELS];
  fmt_t              fmt_q;
  logic [SIZE_W-1:0] width_q;
  logic [SIZE_W-1:0] height_q;
  rgb_q8_t           blend_q[$];
  rgb_q8_t           got;
  rgb_q8_t           want;
  int                err_count;

  function automatic longint texel_chan(logic [WORD_W-1:0] word, int c);
    longint v;
    case (fmt_q)
      FMT_GREY8:  v = longint'(word[7:0]);
      FMT_GREY16: v = $signed(word[15:0]);
      default: begin
        if (c == 0)      v = longint'(word[7:0]);
        else if (c == 1) v = longint'(word[23:16]);
        else             v = longint'(word[31:24]);
      end
    endcase
    return v;
  endfunction

  function automatic rgb_q8_t blend_sample(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
    int              w, h, x0, x1, y0, y1, fa, fb;
    logic [WORD_W-1:0] tx [4];
    longint          wt [4];
    longint          acc;
    chan_q8_t        ch [3];
    w = usable_size(width_q);
    h = usable_size(height_q);
    split_coord(u, w, x0, x1, fa);
    split_coord(v, h, y0, y1, fb);
    tx[0] = texel_mem[y0 * w + x0];
    tx[1] = texel_mem[y1 * w + x0];
    tx[2] = texel_mem[y0 * w + x1];
    tx[3] = texel_mem[y1 * w + x1];
    wt[0] = longint'(WT_ONE - fa) * (WT_ONE - fb);
    wt[1] = longint'(WT_ONE - fa) * fb;
    wt[2] = longint'(fa) * (WT_ONE - fb);
    wt[3] = longint'(fa) * fb;
    for (int c = 0; c < 3; c++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) acc += texel_chan(tx[k], c) * wt[k];
      ch[c] = chan_q8_t'(acc >>> (2 * WEIGHT_FRAC_BITS - 8));  // floor to 8 fraction bits
    end
    return '{blue: ch[2], green: ch[1], red: ch[0]};
  endfunction

  task automatic check_channel(string name, chan_q8_t exp_v, chan_q8_t act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fmt_q     = FMT_RGB;
      width_q   = SIZE_W'(256);
      height_q  = SIZE_W'(256);
      err_count = 0;
      blend_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FORMAT: fmt_q    = fmt_t'(cfg_data[1:0]);
          REG_WIDTH:  width_q  = cfg_data;
          REG_HEIGHT: height_q = cfg_data;
          default: ;
        endcase
      end
      // new expectation before any pop: a result never leaves in its own item's cycle
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == ACT_WRITE)
          texel_mem[in_tdata[15:0]] = in_tdata[47:16];  // chan0, chan1, chan2
        else
          blend_q.push_back(blend_sample(in_tdata[64:48], in_tdata[81:65]));
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (blend_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, out_tdata);
          err_count++;
        end else begin
          want = blend_q.pop_front();
          check_channel("red", want.red, got.red);
          check_channel("green", want.green, got.green);
          check_channel("blue", want.blue, got.blue);
        end
      end
    end
    failures <= err_count;
    pending  <= blend_q.size();
  end

endmodule

/* test/tb_top.sv */
// Bench top for bilinear_texture_sampler: clock, reset, stimulus and verdict.
// Depends on btex_pkg, btex_tb_pkg, btex_checker and the sampler RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import btex_pkg::*;
  import btex_tb_pkg::*;

  localparam int SETTLE_CYCLES = 40;  // front stages plus a full queue of writes
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 54;  // input items sent per phase, fill writes included

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [0:0]  in_tuser   = '0;
  logic [87:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = '0;
  logic [8:0]  cfg_data   = '0;

  int fail_count;
  int results_due;
  int send_idle_pct = 0;
  int sink_stall_pct = 0;
  int sent_count = 0;

  // Our own view of the live image size, so samples only touch written texels.
  logic [SIZE_W-1:0] cur_width  = SIZE_W'(256);
  logic [SIZE_W-1:0] cur_height = SIZE_W'(256);
  bit                texel_written [STORE_TEXELS];

  // Random phase settings; extremes of both sizes are in the list.
  fmt_t phase_fmt [PHASES] = '{FMT_RGB, FMT_GREY8, FMT_GREY16, FMT_RGBA,
                               FMT_GREY16, FMT_RGB, FMT_GREY8, FMT_RGB};
  int   phase_w   [PHASES] = '{256, 1, 256, 17, 5, 1, 64, 12};
  int   phase_h   [PHASES] = '{256, 256, 1, 9, 3, 1, 40, 12};
  // Idle modes cycle: none, sender gaps, receiver stalls, both lightly.
  int   idle_pct  [4]      = '{0, 88, 0, 13};
  int   stall_pct [4]      = '{0, 0, 88, 13};

  bilinear_texture_sampler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  btex_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .failures   (fail_count),
    .pending    (results_due)
  );

  always #4 clk = ~clk;

  // Receiver: random stalls at the rate of the current phase.
  always @(posedge clk) out_tready <= ($urandom_range(99) >= sink_stall_pct);

  // Hard stop well beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // tdata, low bits first: texel_index, chan0, chan1, chan2, coord_u, coord_v, zero pad
  function automatic logic [87:0] pack_fields(logic [15:0] idx, logic [15:0] c0,
                                              logic [7:0] c1, logic [7:0] c2,
                                              logic [16:0] u, logic [16:0] v);
    return {6'b0, v, u, c2, c1, c0, idx};
  endfunction

  function automatic logic [16:0] rand_coord();
    int r;
    r = $urandom_range(99);
    if (r < 10) begin
      // corners of the coordinate range: zero, one half, one, just under two
      case ($urandom_range(3))
        0:       return 17'h00000;
        1:       return 17'h08000;
        2:       return 17'h10000;
        default: return 17'h1FFFF;
      endcase
    end
    if (r < 75) return 17'($urandom_range(65536));  // inside the image
    return 17'($urandom_range(131071));              // past the far edge too
  endfunction

  task automatic cfg_write(logic [1:0] idx, logic [8:0] val);
    if (idx == REG_WIDTH)  cur_width  = val;
    if (idx == REG_HEIGHT) cur_height = val;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // One item on the input channel. tvalid stays high across back-to-back
  // items; it only drops when a gap is drawn.
  task automatic push_item(logic act, logic [87:0] data);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    sent_count++;
  endtask

  task automatic hold_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every expected result, then let trailing writes clear the pipe.
  task automatic drain();
    hold_input();
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_texel(logic [15:0] idx, logic [15:0] c0, logic [7:0] c1,
                             logic [7:0] c2);
    push_item(ACT_WRITE, pack_fields(idx, c0, c1, c2, 17'($urandom), 17'($urandom)));
    texel_written[idx] = 1'b1;
  endtask

  // Fill any of the four neighbor texels not yet written, then sample.
  task automatic sample_at(logic [16:0] u, logic [16:0] v);
    int w, h, x0, x1, y0, y1, frac, addr;
    w = usable_size(cur_width);
    h = usable_size(cur_height);
    split_coord(u, w, x0, x1, frac);
    split_coord(v, h, y0, y1, frac);
    for (int k = 0; k < 4; k++) begin
      addr = ((k & 1) ? y1 : y0) * w + ((k & 2) ? x1 : x0);
      if (!texel_written[addr])
        write_texel(addr[15:0], 16'($urandom), 8'($urandom), 8'($urandom));
    end
    push_item(ACT_SAMPLE, pack_fields(16'($urandom), 16'($urandom), 8'($urandom),
                                      8'($urandom), u, v));
  endtask

  task automatic random_item();
    int r, span;
    r    = $urandom_range(99);
    span = usable_size(cur_width) * usable_size(cur_height);
    if (r < 25)
      write_texel(16'($urandom_range(span - 1)), 16'($urandom), 8'($urandom), 8'($urandom));
    else if (r < 30)  // anywhere in the store, so every index bit moves
      write_texel(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
    else
      sample_at(rand_coord(), rand_coord());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a 2x2 signed-grey image with the chan0 extremes in its corners.
    cfg_write(REG_FORMAT, 9'(FMT_GREY16));
    cfg_write(REG_WIDTH, 9'd2);
    cfg_write(REG_HEIGHT, 9'd2);
    write_texel(16'd0, 16'h8000, 8'hFF, 8'h00);
    write_texel(16'd1, 16'h7FFF, 8'h00, 8'hFF);
    write_texel(16'd2, 16'hFFFF, 8'h80, 8'h7F);
    write_texel(16'd3, 16'h00C3, 8'h3C, 8'hA5);
    sample_at(17'h00000, 17'h00000);  // below the first texel center: clamped low
    sample_at(17'h1FFFF, 17'h1FFFF);  // far past the image: clamped high
    sample_at(17'h08000, 17'h08000);  // dead center, equal weights
    sample_at(17'h0C000, 17'h04000);
    sample_at(17'h10000, 17'h00000);
    sample_at(17'h06000, 17'h0A3FF);  // weight bits below the top 8 dropped

    // Same texels read as unsigned grey bytes, then as colour.
    drain();
    cfg_write(REG_FORMAT, 9'(FMT_GREY8));
    sample_at(17'h08000, 17'h08000);
    sample_at(17'h06000, 17'h0A3FF);
    drain();
    cfg_write(REG_FORMAT, 9'(FMT_RGB));
    sample_at(17'h08000, 17'h08000);
    sample_at(17'h06000, 17'h0A3FF);
    drain();
    cfg_write(REG_FORMAT, 9'(FMT_RGBA));
    sample_at(17'h05000, 17'h0B000);

    // Write to the spare index must not disturb anything; sizes of zero act as one.
    drain();
    cfg_write(REG_SPARE, 9'h1FF);
    cfg_write(REG_WIDTH, 9'd0);
    cfg_write(REG_HEIGHT, 9'd0);
    sample_at(17'h01234, 17'h1FFFF);

    // Sizes above 256 act as 256.
    drain();
    cfg_write(REG_WIDTH, 9'h1FF);
    cfg_write(REG_HEIGHT, 9'd300);
    sample_at(17'h1FFFF, 17'h1FFFF);
    sample_at(17'h08000, 17'h08000);

    // Random phases, each with its own setting and idle mode.
    for (int ph = 0; ph < PHASES; ph++) begin
      int phase_start;
      bit paused;
      drain();
      if (ph == PHASES - 1) begin
        phase_fmt[ph] = fmt_t'($urandom_range(3));
        phase_w[ph]   = $urandom_range(2, 48);
        phase_h[ph]   = $urandom_range(2, 48);
      end
      cfg_write(REG_FORMAT, 9'(phase_fmt[ph]));
      cfg_write(REG_WIDTH, 9'(phase_w[ph]));
      cfg_write(REG_HEIGHT, 9'(phase_h[ph]));
      send_idle_pct  = idle_pct[ph % 4];
      sink_stall_pct = stall_pct[ph % 4];
      phase_start    = sent_count;
      paused         = 1'b0;
      while (sent_count - phase_start < PHASE_ITEMS) begin
        // mid-phase pause until the pipe is empty, then resume cold
        if (ph == 2 && !paused && sent_count - phase_start >= PHASE_ITEMS / 2) begin
          drain();
          paused = 1'b1;
        end
        random_item();
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* bilinear_texture_sampler.f */
hw/rtl/btex_pkg.sv
hw/rtl/btex_front.sv
hw/rtl/btex_queue.sv
hw/rtl/btex_back.sv
hw/rtl/bilinear_texture_sampler.sv
test/btex_tb_pkg.sv
test/btex_checker.sv
test/tb_top.sv
